FILE: rtl/core/pzo_pkg.sv
// ----------------------------------------------------------------------------
// pzo_pkg
// shared types, register indexes and the arctangent table of the
// pole-zero orientation field
// ----------------------------------------------------------------------------
package pzo_pkg;

  localparam int unsigned LANES      = 4;   // two cores then two deltas
  localparam int unsigned POINT_REGS = 2;   // position registers per kind
  localparam int unsigned TABLE_LEN  = 20;
  localparam int unsigned VW         = 28;  // cordic vector and angle width
  localparam int unsigned SW         = 32;  // angle sum width

  localparam logic [2:0] REG_CORE_COUNT  = 3'd0;
  localparam logic [2:0] REG_DELTA_COUNT = 3'd1;
  localparam logic [2:0] REG_CORE_POS0   = 3'd2;
  localparam logic [2:0] REG_CORE_POS1   = 3'd3;
  localparam logic [2:0] REG_DELTA_POS0  = 3'd4;
  localparam logic [2:0] REG_DELTA_POS1  = 3'd5;

  localparam logic signed [VW-1:0] PI_SCALED = 28'sd52707179;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
    logic                 en;
  } pzo_lane_t;

  typedef pzo_lane_t [LANES-1:0] pzo_item_t;

  // round(atan(2^-i) * 2^24)
  function automatic logic signed [VW-1:0] atan_entry(input int unsigned i);
    logic signed [VW-1:0] r;
    r = '0;
    case (i)
      0:  r = 28'sd13176795;
      1:  r = 28'sd7778716;
      2:  r = 28'sd4110060;
      3:  r = 28'sd2086331;
      4:  r = 28'sd1047214;
      5:  r = 28'sd524117;
      6:  r = 28'sd262123;
      7:  r = 28'sd131069;
      8:  r = 28'sd65536;
      9:  r = 28'sd32768;
      10: r = 28'sd16384;
      11: r = 28'sd8192;
      12: r = 28'sd4096;
      13: r = 28'sd2048;
      14: r = 28'sd1024;
      15: r = 28'sd512;
      16: r = 28'sd256;
      17: r = 28'sd128;
      18: r = 28'sd64;
      19: r = 28'sd32;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/pzo_cordic_step.sv
// ----------------------------------------------------------------------------
// pzo_cordic_step
// one registered vectoring cordic iteration applied to every lane
// ----------------------------------------------------------------------------
module pzo_cordic_step import pzo_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pzo_item_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pzo_item_t out_data_o
);

  localparam logic signed [VW-1:0] Ang = atan_entry(IDX);

  logic      valid_q;
  pzo_item_t data_d, data_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    data_d = in_data_i;
    for (int l = 0; l < LANES; l++) begin
      if (in_data_i[l].y != '0) begin
        if (!in_data_i[l].y[VW-1]) begin
          data_d[l].x = in_data_i[l].x + (in_data_i[l].y >>> IDX);
          data_d[l].y = in_data_i[l].y - (in_data_i[l].x >>> IDX);
          data_d[l].z = in_data_i[l].z + Ang;
        end else begin
          data_d[l].x = in_data_i[l].x - (in_data_i[l].y >>> IDX);
          data_d[l].y = in_data_i[l].y + (in_data_i[l].x >>> IDX);
          data_d[l].z = in_data_i[l].z - Ang;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

FILE: rtl/core/pzo_sum.sv
// ----------------------------------------------------------------------------
// pzo_sum
// adds the enabled core angles and subtracts the enabled delta angles
// ----------------------------------------------------------------------------
module pzo_sum import pzo_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pzo_item_t            in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [SW-1:0] out_sum_o
);

  logic                 valid_q;
  logic signed [SW-1:0] sum_d, sum_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    sum_d = '0;
    for (int l = 0; l < LANES; l++) begin
      if (in_data_i[l].en) begin
        if (l < POINT_REGS) begin
          sum_d = sum_d + SW'(in_data_i[l].z);
        end else begin
          sum_d = sum_d - SW'(in_data_i[l].z);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      sum_q <= sum_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_sum_o   = sum_q;

endmodule

FILE: rtl/core/pole_zero_orientation_field.sv
// ----------------------------------------------------------------------------
// pole_zero_orientation_field
// ridge orientation of a pixel as half the signed sum of point angles
// ----------------------------------------------------------------------------
// path: entry register, ANGLE_ITERATIONS (at most 20) cordic stages, sum register and output register
// throughput: one pixel per cycle while the receiver does not stall, one cordic stage per iteration for all lanes
// reset: async active low, clears all valid bits, counts and positions to zero
module pole_zero_orientation_field import pzo_pkg::*; #(
  parameter int unsigned MAX_CORES        = 2,
  parameter int unsigned MAX_DELTAS       = 2,
  parameter int unsigned ANGLE_ITERATIONS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pixel_x [9:0], pixel_y [19:10], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // orientation_angle [15:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned Iters = (ANGLE_ITERATIONS > TABLE_LEN) ? TABLE_LEN
                                                                  : ANGLE_ITERATIONS;
  localparam int unsigned CoreLim  = (MAX_CORES > POINT_REGS) ? POINT_REGS : MAX_CORES;
  localparam int unsigned DeltaLim = (MAX_DELTAS > POINT_REGS) ? POINT_REGS : MAX_DELTAS;

  // configuration
  logic [1:0]  core_cnt_q, delta_cnt_q;
  logic [31:0] pos_q [LANES];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_cnt_q  <= '0;
      delta_cnt_q <= '0;
      for (int l = 0; l < LANES; l++) pos_q[l] <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CORE_COUNT:  core_cnt_q  <= cfg_data_i[1:0];
        REG_DELTA_COUNT: delta_cnt_q <= cfg_data_i[1:0];
        REG_CORE_POS0:   pos_q[0]    <= cfg_data_i;
        REG_CORE_POS1:   pos_q[1]    <= cfg_data_i;
        REG_DELTA_POS0:  pos_q[2]    <= cfg_data_i;
        REG_DELTA_POS1:  pos_q[3]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline chain
  logic      st_valid [Iters+1];
  logic      st_ready [Iters+1];
  pzo_item_t st_data  [Iters+1];

  // entry stage: differences, half-plane fold and start angle
  logic      v0_q;
  pzo_item_t d0_d, d0_q;
  logic [9:0] px, py;
  int unsigned nc, nd;

  assign px = s_axis_tdata[9:0];
  assign py = s_axis_tdata[19:10];
  assign nc = (32'(core_cnt_q) > CoreLim) ? CoreLim : 32'(core_cnt_q);
  assign nd = (32'(delta_cnt_q) > DeltaLim) ? DeltaLim : 32'(delta_cnt_q);

  always_comb begin
    logic signed [17:0] dx, dy;
    logic signed [VW-1:0] xs, ys;
    d0_d = '0;
    for (int l = 0; l < LANES; l++) begin
      dx = {{2{pos_q[l][15]}}, pos_q[l][15:0]} - $signed({4'b0000, px, 4'b0000});
      dy = {{2{pos_q[l][31]}}, pos_q[l][31:16]} - $signed({4'b0000, py, 4'b0000});
      xs = {{2{dx[17]}}, dx, 8'b0};
      ys = {{2{dy[17]}}, dy, 8'b0};
      if (xs[VW-1]) begin
        d0_d[l].x = -xs;
        d0_d[l].y = -ys;
        d0_d[l].z = ys[VW-1] ? -PI_SCALED : PI_SCALED;
      end else begin
        d0_d[l].x = xs;
        d0_d[l].y = ys;
        d0_d[l].z = '0;
      end
      d0_d[l].en = (l < POINT_REGS) ? (l < nc) : ((l - POINT_REGS) < nd);
    end
  end

  assign s_axis_tready = !v0_q || st_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (s_axis_tready) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      d0_q <= d0_d;
    end
  end

  assign st_valid[0] = v0_q;
  assign st_data[0]  = d0_q;

  for (genvar i = 0; i < Iters; i++) begin : g_step
    pzo_cordic_step #(.IDX(i)) u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (st_valid[i]),
      .in_ready_o  (st_ready[i]),
      .in_data_i   (st_data[i]),
      .out_valid_o (st_valid[i+1]),
      .out_ready_i (st_ready[i+1]),
      .out_data_o  (st_data[i+1])
    );
  end

  logic                 sum_valid, sum_ready;
  logic signed [SW-1:0] sum;

  pzo_sum u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (st_valid[Iters]),
    .in_ready_o  (st_ready[Iters]),
    .in_data_i   (st_data[Iters]),
    .out_valid_o (sum_valid),
    .out_ready_i (sum_ready),
    .out_sum_o   (sum)
  );

  // halve with round half up, then saturate
  logic                 out_valid_q;
  logic [15:0]          out_data_q;
  logic signed [SW-1:0] rnd;
  logic signed [18:0]   half;
  logic [15:0]          sat;

  assign rnd  = sum + 32'sd4096;
  assign half = rnd[SW-1:13];
  assign sat  = (half > 19'sd32767)  ? 16'h7fff :
                (half < -19'sd32768) ? 16'h8000 : half[15:0];

  assign sum_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sum_ready) begin
      out_valid_q <= sum_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_ready && sum_valid) begin
      out_data_q <= sat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // input can only stall when the output holds an untaken result
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  a_entry_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v0_q)
    else $error("accepted pixel not held in entry stage");

  a_sum_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_valid && sum_ready |=> out_valid_q)
    else $error("summed item lost before output");

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks pole_zero_orientation_field against a built-in cordic angle predictor,
// with random pixel streams, bursty input, receiver stalls and several
// point configurations
// ----------------------------------------------------------------------------
module testbench;
  import pzo_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITERS = 14;

  // holds the predicted angles of accepted pixels
  class angle_scoreboard;
    logic [15:0] pending_angles[$];
    int unsigned mismatches;
    logic [1:0]  n_cores, n_deltas;
    logic [31:0] core_pos[2];
    logic [31:0] delta_pos[2];

    function new();
      mismatches = 0;
      n_cores = 0;
      n_deltas = 0;
      core_pos[0] = 0;
      core_pos[1] = 0;
      delta_pos[0] = 0;
      delta_pos[1] = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_CORE_COUNT:  n_cores = val[1:0];
        REG_DELTA_COUNT: n_deltas = val[1:0];
        REG_CORE_POS0:   core_pos[0] = val;
        REG_CORE_POS1:   core_pos[1] = val;
        REG_DELTA_POS0:  delta_pos[0] = val;
        REG_DELTA_POS1:  delta_pos[1] = val;
        default: ;
      endcase
    endfunction

    function longint vector_angle(longint x, longint y);
      longint z, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? 64'sd52707179 : -64'sd52707179;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < ITERS && i < TABLE_LEN; i++) begin
        if (y != 0) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z += longint'(atan_entry(i));
          end else begin
            x = x - ys;
            y = y + xs;
            z -= longint'(atan_entry(i));
          end
        end
      end
      return z;
    endfunction

    function longint point_angle(logic [31:0] pos, longint px, longint py);
      longint dx, dy;
      dx = longint'($signed(pos[15:0])) - px * 16;
      dy = longint'($signed(pos[31:16])) - py * 16;
      return vector_angle(dx * 256, dy * 256);
    endfunction

    function void note_pixel(logic [9:0] px, logic [9:0] py);
      longint sum, r;
      int nc, nd;
      sum = 0;
      nc = (n_cores > 2) ? 2 : n_cores;
      nd = (n_deltas > 2) ? 2 : n_deltas;
      for (int k = 0; k < nc; k++) sum += point_angle(core_pos[k], px, py);
      for (int k = 0; k < nd; k++) sum -= point_angle(delta_pos[k], px, py);
      r = (sum + 4096) >>> 13;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      pending_angles.push_back(r[15:0]);
    endfunction

    function void check_angle(logic [15:0] got);
      logic [15:0] want;
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", $signed(got));
        return;
      end
      want = pending_angles.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("angle mismatch: expected %0d actual %0d", $signed(want), $signed(got));
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  angle_scoreboard angles = new();
  bit hold_off = 0;
  bit random_stall = 0;

  pole_zero_orientation_field dut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // receiver: own stall pattern, plus long hold-off on request
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 0;
    else if (!random_stall) m_axis_tready <= 1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) angles.check_angle(m_axis_tdata);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    angles.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // one pixel request; valid stays high if the next follows directly
  task automatic send_pixel(logic [9:0] px, logic [9:0] py, bit keep);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {4'd0, py, px};
    do @(posedge clk_i); while (!s_axis_tready);
    angles.note_pixel(px, py);
    @(negedge clk_i);
    if (!keep) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
  endtask

  task automatic send_burst_random(int count);
    int left;
    left = count;
    @(negedge clk_i);
    while (left > 0) begin
      int len;
      len = $urandom_range(1, 12);
      for (int k = 0; k < len && left > 0; k++) begin
        left--;
        send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                   k < len - 1 && left > 0);
      end
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    while (angles.pending_angles.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_pos();
    // half the time on the pixel grid so exact hits and same-row cases occur
    logic [15:0] x, y;
    if ($urandom_range(0, 1)) begin
      x = {2'b0, 10'($urandom_range(0, 1023)), 4'b0};
      y = {2'b0, 10'($urandom_range(0, 1023)), 4'b0};
    end else begin
      x = 16'($urandom);
      y = 16'($urandom);
    end
    return {y, x};
  endfunction

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // no points enabled: everything is zero
    @(negedge clk_i);
    send_pixel(0, 0, 0);
    send_pixel(1023, 1023, 0);
    drain();

    write_reg(REG_CORE_COUNT, 1);
    write_reg(REG_DELTA_COUNT, 1);
    write_reg(REG_CORE_POS0, {16'd100 << 4, 16'd200 << 4});
    write_reg(REG_CORE_POS1, 32'h8000_7fff);
    write_reg(REG_DELTA_POS0, {16'd300 << 4, 16'd50 << 4});
    write_reg(REG_DELTA_POS1, 32'h7fff_8000);
    @(negedge clk_i);
    send_pixel(200, 100, 0);   // on the core
    send_pixel(50, 300, 0);    // on the delta
    send_pixel(300, 100, 0);   // core to the left on the same row
    send_pixel(200, 0, 0);
    send_pixel(200, 1023, 0);
    send_pixel(0, 300, 0);
    send_pixel(1023, 300, 0);
    send_pixel(0, 1023, 0);
    send_pixel(1023, 0, 0);
    drain();
    // count of 3 acts as 2
    write_reg(REG_CORE_COUNT, 3);
    write_reg(REG_DELTA_COUNT, 3);
    write_reg(3'd7, 32'hffff_ffff);  // ignored index
    @(negedge clk_i);
    send_pixel(0, 0, 0);
    send_pixel(512, 512, 0);
    send_pixel(1023, 1023, 0);
    // two cores, no deltas: cores to the left, on and next to the pixel row
    drain();
    write_reg(REG_DELTA_COUNT, 0);
    write_reg(REG_CORE_COUNT, 2);
    write_reg(REG_CORE_POS0, {16'd10 << 4, 16'd500 << 4});
    write_reg(REG_CORE_POS1, {16'd10 << 4, 16'd600 << 4});
    @(negedge clk_i);
    send_pixel(900, 10, 0);
    send_pixel(1000, 10, 0);
    send_pixel(900, 11, 0);
    send_pixel(900, 9, 0);
    drain();

    // receiver holds off while the sender keeps offering
    hold_off = 1;
    fork
      send_burst_random(60);
      begin
        repeat (200) @(posedge clk_i);
        hold_off = 0;
      end
    join
    drain();

    random_stall = 1;
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_CORE_COUNT, $urandom_range(0, 3));
      write_reg(REG_DELTA_COUNT, $urandom_range(0, 3));
      write_reg(REG_CORE_POS0, rand_pos());
      write_reg(REG_CORE_POS1, rand_pos());
      write_reg(REG_DELTA_POS0, rand_pos());
      write_reg(REG_DELTA_POS1, rand_pos());
      random_stall = phase[0];
      send_burst_random(50);
      drain();
    end

    if (angles.mismatches == 0 && angles.pending_angles.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
